@@ rtl/application_template_tlv_parser_top_macros.svh @@
// Assertion macros used by the checker file
`ifndef APPLICATION_TEMPLATE_TLV_PARSER_TOP_MACROS_SVH
`define APPLICATION_TEMPLATE_TLV_PARSER_TOP_MACROS_SVH

// Condition holds in the same cycle as the trigger
`define ATP_ASSERT_SAME(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition holds in the cycle after the trigger
`define ATP_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

@@ rtl/atp_pkg.sv @@
`timescale 1ns / 1ps

package atp_pkg;

	// Largest AID the store can hold, and the saturation cap of the reported length
	localparam int MAX_AID_BYTES = 16;
	localparam int AID_CAP       = (MAX_AID_BYTES < 31) ? MAX_AID_BYTES : 31;

	// BER-TLV tags
	localparam logic [7:0] TAG_TEMPLATE = 8'h61;
	localparam logic [7:0] TAG_AID      = 8'h4F;
	localparam logic [7:0] TAG_LABEL    = 8'h50;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_TLEN      = 4'd1,
		PH_AIDTAG    = 4'd2,
		PH_AIDLEN    = 4'd3,
		PH_AIDVAL    = 4'd4,
		PH_LABTAG    = 4'd5,
		PH_LABLEN    = 4'd6,
		PH_LABVAL    = 4'd7,
		PH_DONE_OK   = 4'd8,
		PH_DONE_BADT = 4'd9,
		PH_DONE_BADA = 4'd10,
		PH_DONE_LONG = 4'd11
	} phase_t;

	typedef enum logic [3:0] {
		ROLE_IGNORED   = 4'd0,
		ROLE_TMPL_TAG  = 4'd1,
		ROLE_TMPL_LEN  = 4'd2,
		ROLE_AID_TAG   = 4'd3,
		ROLE_AID_LEN   = 4'd4,
		ROLE_AID_BYTE  = 4'd5,
		ROLE_LAB_TAG   = 4'd6,
		ROLE_LAB_LEN   = 4'd7,
		ROLE_LAB_BYTE  = 4'd8,
		ROLE_TRAILER   = 4'd9
	} role_t;

	typedef enum logic [2:0] {
		ST_PROGRESS  = 3'd0,
		ST_COMPLETE  = 3'd1,
		ST_BAD_TMPL  = 3'd2,
		ST_BAD_AID   = 3'd3,
		ST_AID_LONG  = 3'd4
	} status_t;

	// Parser state carried from byte to byte
	typedef struct packed {
		phase_t     phase;
		logic [7:0] tmpl_rem;
		logic [7:0] fld_rem;
		logic [7:0] fld_pos;
		logic [4:0] aid_len;
		logic [7:0] lab_len;
	} state_t;

	// One result item
	typedef struct packed {
		role_t      role;
		logic [7:0] elem_idx;
		status_t    status;
		logic [4:0] aid_len;
		logic [7:0] lab_len;
		logic       rec_end;
	} result_t;

endpackage

@@ rtl/application_template_tlv_parser_top.sv @@
`timescale 1ns / 1ps

// Application template (tag 61) TLV parser. Takes one record byte per cycle
// on the slave stream (s_tuser marks the first byte of a record) and returns
// one result per byte: its role, its index within the AID or label value, the
// running record status, the held AID and label lengths, and m_tlast on the
// byte that completes or aborts the record. Throughput is one byte per clock
// when not stalled, set by the combinational next-state logic of the byte
// FSM; bytes pass the input, then the result register. Back pressure
// on the master side stalls the input only once both registers are full.
// AIDs longer than atp_pkg::MAX_AID_BYTES bytes abort with status 4.
module application_template_tlv_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] first
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [3:0] byte_role, [11:4] element_index,
	                               // [14:12] status, [19:15] aid_length,
	                               // [27:20] label_length, [31:28] zero
	output logic        m_tlast    // record_end
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              first_s1;
	logic              m_valid_q;
	atp_pkg::result_t  result_q;
	atp_pkg::state_t   state_q;
	atp_pkg::state_t   state_nxt;
	atp_pkg::result_t  result_nxt;
	logic              out_free;
	logic              advance;

	// Handshake: output register frees when empty or drained this cycle
	assign out_free = !m_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	atp_step u_step (
		.cur       (state_q),
		.data_byte (byte_s1),
		.first     (first_s1),
		.nxt       (state_nxt),
		.res       (result_nxt)
	);

	// Control: stage valids and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
			state_q   <= '{phase: atp_pkg::PH_IDLE, default: '0};
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				m_valid_q <= 1'b1;
				state_q   <= state_nxt;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tlast  = result_q.rec_end;
	assign m_tdata  = {4'b0000, result_q.lab_len, result_q.aid_len, result_q.status,
		result_q.elem_idx, result_q.role};

endmodule

@@ rtl/atp_step.sv @@
`timescale 1ns / 1ps

// Next-state and result logic of the byte FSM for one record byte
module atp_step (
	input  atp_pkg::state_t  cur,
	input  logic [7:0]       data_byte,
	input  logic             first,
	output atp_pkg::state_t  nxt,
	output atp_pkg::result_t res
);

	logic [7:0] tmpl_dec;
	logic [7:0] fld_dec;

	// Remaining template count stops at zero; field count just decrements
	assign tmpl_dec = (cur.tmpl_rem == 8'd0) ? 8'd0 : cur.tmpl_rem - 8'd1;
	assign fld_dec  = cur.fld_rem - 8'd1;

	always_comb begin
		nxt          = cur;
		res.role     = atp_pkg::ROLE_IGNORED;
		res.elem_idx = 8'd0;
		res.status   = atp_pkg::ST_PROGRESS;
		res.rec_end  = 1'b0;

		if (first) begin
			// New record: drop everything held
			nxt.tmpl_rem = 8'd0;
			nxt.fld_rem  = 8'd0;
			nxt.fld_pos  = 8'd0;
			nxt.aid_len  = 5'd0;
			nxt.lab_len  = 8'd0;
			res.role     = atp_pkg::ROLE_TMPL_TAG;
			if (data_byte == atp_pkg::TAG_TEMPLATE) begin
				nxt.phase = atp_pkg::PH_TLEN;
			end else begin
				res.status  = atp_pkg::ST_BAD_TMPL;
				res.rec_end = 1'b1;
				nxt.phase   = atp_pkg::PH_DONE_BADT;
			end
		end else begin
			unique case (cur.phase)
				atp_pkg::PH_IDLE: begin
				end
				atp_pkg::PH_DONE_OK:   res.status = atp_pkg::ST_COMPLETE;
				atp_pkg::PH_DONE_BADT: res.status = atp_pkg::ST_BAD_TMPL;
				atp_pkg::PH_DONE_BADA: res.status = atp_pkg::ST_BAD_AID;
				atp_pkg::PH_DONE_LONG: res.status = atp_pkg::ST_AID_LONG;
				atp_pkg::PH_TLEN: begin
					res.role     = atp_pkg::ROLE_TMPL_LEN;
					nxt.tmpl_rem = data_byte;
					nxt.phase    = atp_pkg::PH_AIDTAG;
				end
				atp_pkg::PH_AIDTAG: begin
					nxt.tmpl_rem = tmpl_dec;
					res.role     = atp_pkg::ROLE_AID_TAG;
					if (data_byte == atp_pkg::TAG_AID) begin
						nxt.phase = atp_pkg::PH_AIDLEN;
					end else begin
						res.status  = atp_pkg::ST_BAD_AID;
						res.rec_end = 1'b1;
						nxt.phase   = atp_pkg::PH_DONE_BADA;
					end
				end
				atp_pkg::PH_AIDLEN: begin
					nxt.tmpl_rem = tmpl_dec;
					res.role     = atp_pkg::ROLE_AID_LEN;
					nxt.aid_len  = (data_byte > 8'(atp_pkg::AID_CAP)) ?
						5'(atp_pkg::AID_CAP) : data_byte[4:0];
					if (data_byte > 8'(atp_pkg::MAX_AID_BYTES)) begin
						res.status  = atp_pkg::ST_AID_LONG;
						res.rec_end = 1'b1;
						nxt.phase   = atp_pkg::PH_DONE_LONG;
					end else if (data_byte == 8'd0) begin
						// Empty AID: go straight to the label check, or complete if the template is used up
						if (tmpl_dec == 8'd0) begin
							res.status  = atp_pkg::ST_COMPLETE;
							res.rec_end = 1'b1;
							nxt.phase   = atp_pkg::PH_DONE_OK;
						end else begin
							nxt.phase = atp_pkg::PH_LABTAG;
						end
					end else begin
						nxt.fld_rem = data_byte;
						nxt.fld_pos = 8'd0;
						nxt.phase   = atp_pkg::PH_AIDVAL;
					end
				end
				atp_pkg::PH_AIDVAL: begin
					nxt.tmpl_rem = tmpl_dec;
					res.role     = atp_pkg::ROLE_AID_BYTE;
					res.elem_idx = cur.fld_pos;
					nxt.fld_pos  = cur.fld_pos + 8'd1;
					nxt.fld_rem  = fld_dec;
					if (fld_dec == 8'd0) begin
						if (tmpl_dec == 8'd0) begin
							res.status  = atp_pkg::ST_COMPLETE;
							res.rec_end = 1'b1;
							nxt.phase   = atp_pkg::PH_DONE_OK;
						end else begin
							nxt.phase = atp_pkg::PH_LABTAG;
						end
					end
				end
				atp_pkg::PH_LABTAG: begin
					nxt.tmpl_rem = tmpl_dec;
					if (data_byte == atp_pkg::TAG_LABEL) begin
						res.role  = atp_pkg::ROLE_LAB_TAG;
						nxt.phase = atp_pkg::PH_LABLEN;
					end else begin
						res.role    = atp_pkg::ROLE_TRAILER;
						res.status  = atp_pkg::ST_COMPLETE;
						res.rec_end = 1'b1;
						nxt.phase   = atp_pkg::PH_DONE_OK;
					end
				end
				atp_pkg::PH_LABLEN: begin
					nxt.tmpl_rem = tmpl_dec;
					res.role     = atp_pkg::ROLE_LAB_LEN;
					nxt.lab_len  = data_byte;
					if (data_byte == 8'd0) begin
						res.status  = atp_pkg::ST_COMPLETE;
						res.rec_end = 1'b1;
						nxt.phase   = atp_pkg::PH_DONE_OK;
					end else begin
						nxt.fld_rem = data_byte;
						nxt.fld_pos = 8'd0;
						nxt.phase   = atp_pkg::PH_LABVAL;
					end
				end
				atp_pkg::PH_LABVAL: begin
					nxt.tmpl_rem = tmpl_dec;
					res.role     = atp_pkg::ROLE_LAB_BYTE;
					res.elem_idx = cur.fld_pos;
					nxt.fld_pos  = cur.fld_pos + 8'd1;
					nxt.fld_rem  = fld_dec;
					if (fld_dec == 8'd0) begin
						res.status  = atp_pkg::ST_COMPLETE;
						res.rec_end = 1'b1;
						nxt.phase   = atp_pkg::PH_DONE_OK;
					end
				end
				default: begin
					// Unused phase codes fall back to waiting for a record
					nxt.phase = atp_pkg::PH_IDLE;
				end
			endcase
		end

		res.aid_len = nxt.aid_len;
		res.lab_len = nxt.lab_len;
	end

endmodule

@@ rtl/atp_checker.sv @@
`timescale 1ns / 1ps

`include "application_template_tlv_parser_top_macros.svh"

// Port-level checks on the parser's result stream
module atp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	// A stalled transaction keeps its contents
	`ATP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

	// A record only ends with a final status
	`ATP_ASSERT_SAME(a_end_status, m_tvalid && m_tlast, m_tdata[14:12] != atp_pkg::ST_PROGRESS, "record end with in-progress status")

	// Element index is only set on AID or label value bytes
	`ATP_ASSERT_SAME(a_idx_role, m_tvalid && m_tdata[11:4] != 8'd0, m_tdata[3:0] == atp_pkg::ROLE_AID_BYTE || m_tdata[3:0] == atp_pkg::ROLE_LAB_BYTE, "element index on a non-value byte")

	// Held AID length never exceeds the store, and pad bits [31:28] stay zero
	`ATP_ASSERT_SAME(a_aid_cap, m_tvalid, m_tdata[19:15] <= 5'(atp_pkg::AID_CAP) && m_tdata[31:28] == 4'd0, "AID length above cap or pad bits set")

endmodule

bind application_template_tlv_parser_top atp_checker u_atp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
